@@ src/rtp_pkg.sv @@
// Shared types, widths, register indexes and saturation helpers for the
// rigid point transform. No dependencies; used by every module in src.
`timescale 1ns / 1ps

package rtp_pkg;

  // Coordinate and coefficient formats: Q16.16 coordinates, Q2.16 coefficients
  localparam int COORD_W   = 32;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int DIMS      = 3;
  localparam int ROW_W     = DIMS * COEF_W;

  // Exact product, rounded product and three-term accumulator widths
  localparam int MUL_W  = COORD_W + COEF_W;
  localparam int PROD_W = MUL_W - COEF_FRAC;
  localparam int ACC_W  = PROD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = ROW_W;
  localparam int BAND_W     = 16;
  localparam logic [BAND_W-1:0] BAND_RESET = BAND_W'(32);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_0    = 3'd0,
    REG_ROW_1    = 3'd1,
    REG_ROW_2    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_ZERO_BAND = 3'd6
  } cfg_reg_t;

  // Control passed from the top level to each output lane
  typedef struct packed {
    logic load;   // capture the products of the next point
    logic back;   // point uses the transposed matrix and adds the offset
  } lane_ctl_t;

  // Half an LSB at coordinate scale, added before the product is floored
  localparam mul_t ROUND_HALF = mul_t'(1) <<< (COEF_FRAC - 1);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = ~COORD_MAX;
  localparam acc_t   ACC_MAX   = acc_t'(COORD_MAX);
  localparam acc_t   ACC_MIN   = acc_t'(COORD_MIN);

  // Clamp an accumulator value to the coordinate range
  function automatic coord_t sat_coord(input acc_t v);
    coord_t r;
    if (v > ACC_MAX) begin
      r = COORD_MAX;
    end else if (v < ACC_MIN) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/rtp_lane.sv @@
// One output coordinate of the rigid point transform: three rounded
// multiplies into a product register, then sum, offset and deadband logic.
// Depends on rtp_pkg.
`timescale 1ns / 1ps

module rtp_lane (
  input  logic                      clk,
  input  rtp_pkg::lane_ctl_t        ctl,
  input  rtp_pkg::coord_t           p [rtp_pkg::DIMS],
  input  rtp_pkg::coef_t            c [rtp_pkg::DIMS],
  input  rtp_pkg::coord_t           offset,
  input  logic [rtp_pkg::BAND_W-1:0] zero_band,
  output rtp_pkg::coord_t           res
);

  rtp_pkg::mul_t   mul_full [rtp_pkg::DIMS];
  rtp_pkg::mul_t   mul_rnd  [rtp_pkg::DIMS];
  rtp_pkg::prod_t  prod_nxt [rtp_pkg::DIMS];
  rtp_pkg::prod_t  prod_r   [rtp_pkg::DIMS];
  logic            back_r;
  rtp_pkg::acc_t   sum;
  rtp_pkg::coord_t sum_sat;
  rtp_pkg::coord_t moved;
  rtp_pkg::acc_t   moved_ext;
  rtp_pkg::acc_t   band;

  // Round each product to nearest at coordinate scale (ties up)
  always_comb begin
    for (int j = 0; j < rtp_pkg::DIMS; j++) begin
      mul_full[j] = c[j] * p[j];
      mul_rnd[j]  = mul_full[j] + rtp_pkg::ROUND_HALF;
      prod_nxt[j] = mul_rnd[j][rtp_pkg::MUL_W-1:rtp_pkg::COEF_FRAC];
    end
  end

  // Hold products until the next stage moves
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod_r <= prod_nxt;
      back_r <= ctl.back;
    end
  end

  // Sum, saturate, add offset in back mode, then snap small values to zero
  always_comb begin
    sum = rtp_pkg::acc_t'(prod_r[0]) + rtp_pkg::acc_t'(prod_r[1])
        + rtp_pkg::acc_t'(prod_r[2]);
    sum_sat = rtp_pkg::sat_coord(sum);
    if (back_r) begin
      moved = rtp_pkg::sat_coord(rtp_pkg::acc_t'(sum_sat) + rtp_pkg::acc_t'(offset));
    end else begin
      moved = sum_sat;
    end
    moved_ext = rtp_pkg::acc_t'(moved);
    band      = rtp_pkg::acc_t'({1'b0, zero_band});
    if ((moved_ext >= -band) && (moved_ext <= band)) begin
      res = '0;
    end else begin
      res = moved;
    end
  end

endmodule

@@ src/rigid_transform_point_top.sv @@
// Top level of the rigid point transform: configuration registers, input
// stage, pre-subtract stage, three output lanes and the result register.
// Depends on rtp_pkg and rtp_lane.
`timescale 1ns / 1ps

// Accepts one point per cycle unless out_tready stalls the result stream; four
// registered stages (input, offset subtract, product, result) each advance on
// their own when the next is free.
// Reset (synchronous, rst_n low) empties all stages, clears the matrix and
// offsets and sets zero_band to 32.
module rigid_transform_point_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [rtp_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [rtp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [95:0]                   in_tdata,  // in_x[31:0], in_y[63:32], in_z[95:64]
  input  logic [0:0]                    in_tuser,  // mode[0]
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [95:0]                   out_tdata  // out_x[31:0], out_y[63:32], out_z[95:64]
);

  localparam int D = rtp_pkg::DIMS;
  localparam int W = rtp_pkg::COORD_W;

  // Configuration registers
  logic [rtp_pkg::ROW_W-1:0]  row_r [D];
  rtp_pkg::coord_t            offset_r [D];
  logic [rtp_pkg::BAND_W-1:0] zero_band_r;

  // Pipeline state
  logic            v1_r, v2_r, v3_r, out_valid_r;
  logic            back1_r, back2_r;
  rtp_pkg::coord_t pt1_r [D];
  rtp_pkg::coord_t p2_r  [D];
  rtp_pkg::coord_t p2_nxt [D];
  rtp_pkg::coord_t res   [D];
  rtp_pkg::coord_t out_r [D];
  rtp_pkg::coef_t  coef  [D][D];
  rtp_pkg::coef_t  lane_coef [D][D];
  logic            adv2, adv3, adv_out;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < D; i++) begin
        row_r[i]    <= '0;
        offset_r[i] <= '0;
      end
      zero_band_r <= rtp_pkg::BAND_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rtp_pkg::REG_ROW_0:     row_r[0]    <= cfg_wdata;
        rtp_pkg::REG_ROW_1:     row_r[1]    <= cfg_wdata;
        rtp_pkg::REG_ROW_2:     row_r[2]    <= cfg_wdata;
        rtp_pkg::REG_OFFSET_X:  offset_r[0] <= cfg_wdata[W-1:0];
        rtp_pkg::REG_OFFSET_Y:  offset_r[1] <= cfg_wdata[W-1:0];
        rtp_pkg::REG_OFFSET_Z:  offset_r[2] <= cfg_wdata[W-1:0];
        rtp_pkg::REG_ZERO_BAND: zero_band_r <= cfg_wdata[rtp_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage advance: each stage moves when empty or when the next one moves
  assign adv_out   = !out_valid_r || out_tready;
  assign adv3      = !v3_r || adv_out;
  assign adv2      = !v2_r || adv3;
  assign in_tready = !v1_r || adv2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) v1_r        <= in_tvalid;
      if (adv2)      v2_r        <= v1_r;
      if (adv3)      v3_r        <= v2_r;
      if (adv_out)   out_valid_r <= v3_r;
    end
  end

  // Capture the input point
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      back1_r <= in_tuser[0];
      for (int i = 0; i < D; i++) begin
        pt1_r[i] <= in_tdata[i*W +: W];
      end
    end
  end

  // Forward mode subtracts the offset first
  always_comb begin
    for (int i = 0; i < D; i++) begin
      if (back1_r) begin
        p2_nxt[i] = pt1_r[i];
      end else begin
        p2_nxt[i] = rtp_pkg::sat_coord(rtp_pkg::acc_t'(pt1_r[i])
                                       - rtp_pkg::acc_t'(offset_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      back2_r <= back1_r;
      p2_r    <= p2_nxt;
    end
  end

  // Unpack coefficients and pick rows or columns per lane
  always_comb begin
    for (int r = 0; r < D; r++) begin
      for (int k = 0; k < D; k++) begin
        coef[r][k] = row_r[r][k*rtp_pkg::COEF_W +: rtp_pkg::COEF_W];
      end
    end
    for (int i = 0; i < D; i++) begin
      for (int j = 0; j < D; j++) begin
        lane_coef[i][j] = back2_r ? coef[j][i] : coef[i][j];
      end
    end
  end

  for (genvar g = 0; g < D; g++) begin : g_lane
    rtp_pkg::lane_ctl_t ctl;
    assign ctl.load = adv3;
    assign ctl.back = back2_r;

    rtp_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .p         (p2_r),
      .c         (lane_coef[g]),
      .offset    (offset_r[g]),
      .zero_band (zero_band_r),
      .res       (res[g])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  always_comb begin
    for (int i = 0; i < D; i++) begin
      out_tdata[i*W +: W] = out_r[i];
    end
  end

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // An accepted point lands in the input stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted point lost at input stage");

  // A stalled product stage keeps its point
  a_prod_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !adv3) |=> v3_r)
    else $error("product stage dropped a point while stalled");

  // A full product stage that advances fills the result register
  a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && adv_out) |=> out_tvalid)
    else $error("result register not filled");

endmodule
